// ===== src/pes_hdr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PES header parser package
// Request and result types, stream id codes and stream class codes shared by
// the PES header parser.
// ----------------------------------------------------------------------------
package pes_hdr_pkg;

    // One byte of the packet stream.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } byte_req_t;

    // One header summary.
    typedef struct packed {
        logic        start_code_ok;
        logic [7:0]  sid_byte;
        logic [15:0] packet_length;
        logic [1:0]  stream_class;
        logic [15:0] flag_bits;
        logic [7:0]  header_data_length;
        logic [32:0] pts_value;
        logic [32:0] dts_value;
        logic [32:0] escr_clock;
        logic [8:0]  escr_ext;
        logic [21:0] es_rate;
    } hdr_result_t;

    // Stream class codes.
    localparam logic [1:0] CLASS_OPT_HDR   = 2'd0;
    localparam logic [1:0] CLASS_DATA_ONLY = 2'd1;
    localparam logic [1:0] CLASS_PADDING   = 2'd2;

    // Stream ids with special handling.
    localparam logic [7:0] SID_PROGRAM_MAP = 8'hBC;
    localparam logic [7:0] SID_PADDING     = 8'hBE;
    localparam logic [7:0] SID_PRIVATE_2   = 8'hBF;
    localparam logic [7:0] SID_ECM         = 8'hF0;
    localparam logic [7:0] SID_EMM         = 8'hF1;
    localparam logic [7:0] SID_DSMCC       = 8'hF2;
    localparam logic [7:0] SID_TYPE_E      = 8'hF8;
    localparam logic [7:0] SID_DIRECTORY   = 8'hFF;

    localparam logic [23:0] START_CODE_PREFIX = 24'h000001;

    // Bytes before the optional fields, in the order they arrive.
    localparam logic [4:0] IDX_PREFIX_LAST = 5'd2;
    localparam logic [4:0] IDX_SID         = 5'd3;
    localparam logic [4:0] IDX_LENGTH_HI   = 5'd4;
    localparam logic [4:0] IDX_LENGTH_LO   = 5'd5;
    localparam logic [4:0] IDX_FLAGS_HI    = 5'd6;
    localparam logic [4:0] IDX_FLAGS_LO    = 5'd7;
    localparam logic [4:0] IDX_HDR_LEN     = 5'd8;

    // Field sizes in bytes.
    localparam logic [4:0] STAMP_BYTES = 5'd5;
    localparam logic [4:0] ESCR_BYTES  = 5'd6;
    localparam logic [4:0] RATE_BYTES  = 5'd3;

    // True for the stream ids other than padding that carry no optional header.
    function automatic logic is_data_only(input logic [7:0] sid);
        return (sid == SID_PROGRAM_MAP) || (sid == SID_PRIVATE_2) ||
               (sid == SID_ECM) || (sid == SID_EMM) || (sid == SID_DSMCC) ||
               (sid == SID_TYPE_E) || (sid == SID_DIRECTORY);
    endfunction

endpackage
`default_nettype wire

// ===== src/pes_header_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PES header parser
// Parses the header of each PES packet from a byte stream and emits one
// summary per packet with the start code check, stream id, packet length,
// flag bytes, header data length and the assembled PTS, DTS, ESCR and ES rate.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+-------------------------------
//  request  | byte_valid / byte_stall     | byte_data   (byte_req_t)
//  result   | result_valid / result_stall | result_data (hdr_result_t)
//
// One request is accepted in every cycle in which the result register is free
// or being drained. Each byte is folded into the parse state in the cycle it
// is accepted, and a finished summary lands in the result register at the same
// edge, so result_valid rises in the cycle after the last header byte is taken.
// byte_stall is raised only while a summary sits in the result register and
// the consumer stalls it. Reset clears the parse state and the result valid.
//
module pes_header_parser (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      byte_valid,
    output logic                     byte_stall,
    input  pes_hdr_pkg::byte_req_t   byte_data,
    output logic                     result_valid,
    input  wire                      result_stall,
    output pes_hdr_pkg::hdr_result_t result_data
);

    // Parse state.
    logic [4:0]  byte_index_reg,   byte_index_next;
    logic        parse_active_reg, parse_active_next;
    logic        code_good_reg,    code_good_next;
    logic [7:0]  id_reg,           id_next;
    logic [15:0] length_reg,       length_next;
    logic [15:0] flags_reg,        flags_next;
    logic [7:0]  hdr_len_reg,      hdr_len_next;
    logic [47:0] field_shift_reg,  field_shift_next;
    logic [32:0] pts_reg,          pts_next;
    logic [32:0] dts_reg,          dts_next;
    logic [41:0] escr_reg,         escr_next;
    logic [21:0] rate_reg,         rate_next;

    // Result register.
    logic                     result_valid_reg;
    pes_hdr_pkg::hdr_result_t result_reg, result_next;

    logic        accept;
    logic        emit;
    logic [1:0]  emit_class;

    // State as seen by the current byte: a first byte starts a fresh packet.
    logic        base_active;
    logic [4:0]  base_index;
    logic        base_code_good;
    logic [7:0]  base_id;
    logic [15:0] base_length;
    logic [15:0] base_flags;
    logic [7:0]  base_hdr_len;
    logic [47:0] base_shift;
    logic [32:0] base_pts;
    logic [32:0] base_dts;
    logic [41:0] base_escr;
    logic [21:0] base_rate;

    logic [47:0] shifted;
    logic [4:0]  pts_end;
    logic [4:0]  dts_end;
    logic [4:0]  escr_end;
    logic [4:0]  rate_end;
    logic [4:0]  pos;

    assign byte_stall = result_valid_reg && result_stall;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        if (byte_data.first_byte)
        begin
            base_active    = 1'b1;
            base_index     = '0;
            base_code_good = 1'b0;
            base_id        = '0;
            base_length    = '0;
            base_flags     = '0;
            base_hdr_len   = '0;
            base_shift     = '0;
            base_pts       = '0;
            base_dts       = '0;
            base_escr      = '0;
            base_rate      = '0;
        end
        else
        begin
            base_active    = parse_active_reg;
            base_index     = byte_index_reg;
            base_code_good = code_good_reg;
            base_id        = id_reg;
            base_length    = length_reg;
            base_flags     = flags_reg;
            base_hdr_len   = hdr_len_reg;
            base_shift     = field_shift_reg;
            base_pts       = pts_reg;
            base_dts       = dts_reg;
            base_escr      = escr_reg;
            base_rate      = rate_reg;
        end
    end

    assign shifted = {base_shift[39:0], byte_data.data_byte};

    // End positions of the optional fields, counted in bytes after the
    // header data length byte. Only meaningful once both flag bytes are in.
    assign pts_end  = base_flags[7] ? pes_hdr_pkg::STAMP_BYTES : 5'd0;
    assign dts_end  = pts_end + ((base_flags[7:6] == 2'b11) ?
                                 pes_hdr_pkg::STAMP_BYTES : 5'd0);
    assign escr_end = dts_end + (base_flags[5] ? pes_hdr_pkg::ESCR_BYTES : 5'd0);
    assign rate_end = escr_end + (base_flags[4] ? pes_hdr_pkg::RATE_BYTES : 5'd0);
    assign pos      = base_index - pes_hdr_pkg::IDX_HDR_LEN;

    always_comb
    begin
        byte_index_next   = byte_index_reg;
        parse_active_next = parse_active_reg;
        code_good_next    = code_good_reg;
        id_next           = id_reg;
        length_next       = length_reg;
        flags_next        = flags_reg;
        hdr_len_next      = hdr_len_reg;
        field_shift_next  = field_shift_reg;
        pts_next          = pts_reg;
        dts_next          = dts_reg;
        escr_next         = escr_reg;
        rate_next         = rate_reg;
        emit              = 1'b0;
        emit_class        = pes_hdr_pkg::CLASS_OPT_HDR;

        if (accept)
        begin
            parse_active_next = base_active;
            code_good_next    = base_code_good;
            id_next           = base_id;
            length_next       = base_length;
            flags_next        = base_flags;
            hdr_len_next      = base_hdr_len;
            pts_next          = base_pts;
            dts_next          = base_dts;
            escr_next         = base_escr;
            rate_next         = base_rate;
            byte_index_next   = base_index;
            field_shift_next  = base_shift;

            if (base_active)
            begin
                byte_index_next  = base_index + 5'd1;
                field_shift_next = shifted;

                if (base_index < pes_hdr_pkg::IDX_PREFIX_LAST)
                begin
                    // Leading prefix bytes only feed the shift register.
                end
                else if (base_index == pes_hdr_pkg::IDX_PREFIX_LAST)
                begin
                    code_good_next   = (shifted[23:0] == pes_hdr_pkg::START_CODE_PREFIX);
                    field_shift_next = '0;
                end
                else if (base_index == pes_hdr_pkg::IDX_SID)
                begin
                    id_next          = byte_data.data_byte;
                    field_shift_next = '0;
                end
                else if (base_index == pes_hdr_pkg::IDX_LENGTH_HI)
                begin
                    length_next      = {byte_data.data_byte, 8'h00};
                    field_shift_next = '0;
                end
                else if (base_index == pes_hdr_pkg::IDX_LENGTH_LO)
                begin
                    length_next      = {base_length[15:8], byte_data.data_byte};
                    field_shift_next = '0;
                    if (pes_hdr_pkg::is_data_only(base_id))
                    begin
                        parse_active_next = 1'b0;
                        emit              = 1'b1;
                        emit_class        = pes_hdr_pkg::CLASS_DATA_ONLY;
                    end
                    else if (base_id == pes_hdr_pkg::SID_PADDING)
                    begin
                        parse_active_next = 1'b0;
                        emit              = 1'b1;
                        emit_class        = pes_hdr_pkg::CLASS_PADDING;
                    end
                end
                else if (base_index == pes_hdr_pkg::IDX_FLAGS_HI)
                begin
                    flags_next       = {byte_data.data_byte, 8'h00};
                    field_shift_next = '0;
                end
                else if (base_index == pes_hdr_pkg::IDX_FLAGS_LO)
                begin
                    flags_next       = {base_flags[15:8], byte_data.data_byte};
                    field_shift_next = '0;
                end
                else if (base_index == pes_hdr_pkg::IDX_HDR_LEN)
                begin
                    hdr_len_next     = byte_data.data_byte;
                    field_shift_next = '0;
                    if (rate_end == 5'd0)
                    begin
                        parse_active_next = 1'b0;
                        emit              = 1'b1;
                    end
                end
                else
                begin
                    // Optional fields; a field is captured on its last byte.
                    priority if (pos == pts_end && pts_end != 5'd0)
                    begin
                        pts_next         = {shifted[35:33], shifted[31:17], shifted[15:1]};
                        field_shift_next = '0;
                    end
                    else if (pos == dts_end && dts_end != pts_end)
                    begin
                        dts_next         = {shifted[35:33], shifted[31:17], shifted[15:1]};
                        field_shift_next = '0;
                    end
                    else if (pos == escr_end && escr_end != dts_end)
                    begin
                        escr_next        = {shifted[45:43], shifted[41:27],
                                            shifted[25:11], shifted[9:1]};
                        field_shift_next = '0;
                    end
                    else if (pos == rate_end && rate_end != escr_end)
                    begin
                        rate_next        = shifted[22:1];
                        field_shift_next = '0;
                    end
                    else
                    begin
                        // Inside a field: keep shifting.
                    end

                    if (pos >= rate_end)
                    begin
                        parse_active_next = 1'b0;
                        emit              = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        result_next.start_code_ok      = code_good_next;
        result_next.sid_byte           = id_next;
        result_next.packet_length      = length_next;
        result_next.stream_class       = emit_class;
        result_next.flag_bits          = flags_next;
        result_next.header_data_length = hdr_len_next;
        result_next.pts_value          = pts_next;
        result_next.dts_value          = dts_next;
        result_next.escr_clock         = escr_next[41:9];
        result_next.escr_ext           = escr_next[8:0];
        result_next.es_rate            = rate_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= '0;
            parse_active_reg <= 1'b0;
            code_good_reg    <= 1'b0;
            id_reg           <= '0;
            length_reg       <= '0;
            flags_reg        <= '0;
            hdr_len_reg      <= '0;
            field_shift_reg  <= '0;
            pts_reg          <= '0;
            dts_reg          <= '0;
            escr_reg         <= '0;
            rate_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            byte_index_reg   <= byte_index_next;
            parse_active_reg <= parse_active_next;
            code_good_reg    <= code_good_next;
            id_reg           <= id_next;
            length_reg       <= length_next;
            flags_reg        <= flags_next;
            hdr_len_reg      <= hdr_len_next;
            field_shift_reg  <= field_shift_next;
            pts_reg          <= pts_next;
            dts_reg          <= dts_next;
            escr_reg         <= escr_next;
            rate_reg         <= rate_next;
            if (emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // The summary payload needs no reset; it is qualified by result_valid.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule
`default_nettype wire

// ===== test/pes_header_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PES header parser testbench
// A byte stream of PES packets goes through the parser. Each byte is folded
// into a local copy of the parse state, and every header summary that comes
// out is compared field by field with the predicted one. The run starts with
// a short table of directed bytes and then moves on to random packets, broken
// packets and noise. Both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module pes_header_parser_test;

    // Run shape.
    localparam int RESET_CYCLES   = 12;
    localparam int ITEM_TARGET    = 1500;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int HOLDOFF_AT_1   = 1500;
    localparam int HOLDOFF_AT_2   = 4000;
    localparam int MAX_REPORTS    = 40;
    localparam int DIR_ROWS       = 25;

    // Flag bits in the second flag byte.
    localparam int ESCR_FLAG_BIT = 5;
    localparam int RATE_FLAG_BIT = 4;
    localparam logic [1:0] PTS_AND_DTS = 2'b11;

    // Receiver stall modes.
    localparam int RX_FREE  = 0;
    localparam int RX_LIGHT = 1;
    localparam int RX_HEAVY = 2;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     byte_valid = 1'b0;
    logic                     byte_stall;
    pes_hdr_pkg::byte_req_t   byte_data = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    pes_hdr_pkg::hdr_result_t result_data;

    pes_header_parser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------------
    // Header state as the parser should hold it. The names follow the fields
    // of a PES header: the byte position, whether a packet is being parsed,
    // the captured fixed fields and the assembled optional fields.
    // ------------------------------------------------------------------------
    logic [4:0]  pes_pos;
    logic        pes_active;
    logic        code_good;
    logic [7:0]  sid_held;
    logic [15:0] plen_held;
    logic [15:0] flags_held;
    logic [7:0]  hlen_held;
    logic [47:0] field_bytes;
    logic [32:0] pts_held;
    logic [32:0] dts_held;
    logic [41:0] escr_held;
    logic [21:0] rate_held;

    // Expected header summaries, oldest first.
    pes_hdr_pkg::hdr_result_t pending_summaries[$];

    // Bytes of the random packet being sent.
    pes_hdr_pkg::byte_req_t   packet_bytes[$];

    int parsed_bytes       = 0;
    int requests_sent      = 0;
    int summaries_checked  = 0;
    int mismatch_count     = 0;
    int input_stall_cycles = 0;
    int class_seen[4]      = '{0, 0, 0, 0};
    int burst_left         = 0;

    // Receiver pattern state.
    int holdoff_left = 0;
    int phase_left   = 0;
    int rx_mode      = RX_FREE;

    logic [7:0] data_only_ids[7] = '{pes_hdr_pkg::SID_PROGRAM_MAP,
                                     pes_hdr_pkg::SID_PRIVATE_2,
                                     pes_hdr_pkg::SID_ECM,
                                     pes_hdr_pkg::SID_EMM,
                                     pes_hdr_pkg::SID_DSMCC,
                                     pes_hdr_pkg::SID_TYPE_E,
                                     pes_hdr_pkg::SID_DIRECTORY};

    // One row of the directed table. Rows with a typed summary carry the
    // expected result in full; all other rows rely on the header state.
    typedef struct {
        logic [7:0]               data;
        logic                     first;
        logic                     typed;
        pes_hdr_pkg::hdr_result_t want;
    } table_row_t;

    table_row_t dir_table[DIR_ROWS];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // Stream ids other than padding that carry no optional header at all.
    function automatic logic data_only_sid(input logic [7:0] sid);
        case (sid)
            pes_hdr_pkg::SID_PROGRAM_MAP, pes_hdr_pkg::SID_PRIVATE_2,
            pes_hdr_pkg::SID_ECM, pes_hdr_pkg::SID_EMM,
            pes_hdr_pkg::SID_DSMCC, pes_hdr_pkg::SID_TYPE_E,
            pes_hdr_pkg::SID_DIRECTORY: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // A 33-bit time stamp spread over five bytes: three high bits, then two
    // groups of fifteen, each group followed by a marker bit.
    function automatic logic [32:0] stamp33(input logic [47:0] v);
        return {v[35:33], v[31:17], v[15:1]};
    endfunction

    // Summary with zero in every field that a short header leaves empty.
    function automatic pes_hdr_pkg::hdr_result_t summary_of(input logic good,
                                                            input logic [7:0] sid,
                                                            input logic [15:0] plen,
                                                            input logic [1:0] cls,
                                                            input logic [15:0] flags);
        pes_hdr_pkg::hdr_result_t s;
        s = '0;
        s.start_code_ok = good;
        s.sid_byte      = sid;
        s.packet_length = plen;
        s.stream_class  = cls;
        s.flag_bits     = flags;
        return s;
    endfunction

    function automatic pes_hdr_pkg::hdr_result_t current_summary(input logic [1:0] cls);
        pes_hdr_pkg::hdr_result_t s;
        s.start_code_ok      = code_good;
        s.sid_byte           = sid_held;
        s.packet_length      = plen_held;
        s.stream_class       = cls;
        s.flag_bits          = flags_held;
        s.header_data_length = hlen_held;
        s.pts_value          = pts_held;
        s.dts_value          = dts_held;
        s.escr_clock         = escr_held[41:9];
        s.escr_ext           = escr_held[8:0];
        s.es_rate            = rate_held;
        return s;
    endfunction

    task automatic clear_header_state();
        pes_pos     = '0;
        code_good   = 1'b0;
        sid_held    = '0;
        plen_held   = '0;
        flags_held  = '0;
        hlen_held   = '0;
        field_bytes = '0;
        pts_held    = '0;
        dts_held    = '0;
        escr_held   = '0;
        rate_held   = '0;
    endtask

    // Folds one accepted byte into the header state. A finished header ends
    // the packet and hands back its summary.
    task automatic parse_byte(input pes_hdr_pkg::byte_req_t r, output logic made,
                              output pes_hdr_pkg::hdr_result_t summary);
        logic [4:0] idx;
        logic [4:0] pts_end;
        logic [4:0] dts_end;
        logic [4:0] escr_end;
        logic [4:0] rate_end;
        logic [4:0] pos;
        logic [7:0] b;
        made    = 1'b0;
        summary = '0;
        b       = r.data_byte;
        // A first byte always starts over, even in the middle of a header.
        if (r.first_byte)
        begin
            clear_header_state();
            pes_active = 1'b1;
        end
        if (!pes_active)
        begin
            return;
        end
        parsed_bytes++;
        idx         = pes_pos;
        pes_pos     = pes_pos + 5'd1;
        field_bytes = {field_bytes[39:0], b};
        if (idx <= pes_hdr_pkg::IDX_PREFIX_LAST)
        begin
            // A bad prefix is only reported; parsing goes on.
            if (idx == pes_hdr_pkg::IDX_PREFIX_LAST)
            begin
                code_good   = (field_bytes[23:0] == pes_hdr_pkg::START_CODE_PREFIX);
                field_bytes = '0;
            end
            return;
        end
        if (idx == pes_hdr_pkg::IDX_SID)
        begin
            sid_held    = b;
            field_bytes = '0;
            return;
        end
        if (idx == pes_hdr_pkg::IDX_LENGTH_HI)
        begin
            plen_held   = {b, 8'h00};
            field_bytes = '0;
            return;
        end
        if (idx == pes_hdr_pkg::IDX_LENGTH_LO)
        begin
            plen_held[7:0] = b;
            field_bytes    = '0;
            if (data_only_sid(sid_held))
            begin
                pes_active = 1'b0;
                made       = 1'b1;
                summary    = current_summary(pes_hdr_pkg::CLASS_DATA_ONLY);
            end
            else if (sid_held == pes_hdr_pkg::SID_PADDING)
            begin
                pes_active = 1'b0;
                made       = 1'b1;
                summary    = current_summary(pes_hdr_pkg::CLASS_PADDING);
            end
            return;
        end
        if (idx == pes_hdr_pkg::IDX_FLAGS_HI)
        begin
            flags_held  = {b, 8'h00};
            field_bytes = '0;
            return;
        end
        if (idx == pes_hdr_pkg::IDX_FLAGS_LO)
        begin
            flags_held[7:0] = b;
            field_bytes     = '0;
            return;
        end
        // Positions where each optional field ends, counted from the byte
        // after the header data length. DTS alone (flags 01) reads nothing.
        pts_end  = flags_held[7] ? pes_hdr_pkg::STAMP_BYTES : 5'd0;
        dts_end  = pts_end + ((flags_held[7:6] == PTS_AND_DTS) ?
                              pes_hdr_pkg::STAMP_BYTES : 5'd0);
        escr_end = dts_end + (flags_held[ESCR_FLAG_BIT] ? pes_hdr_pkg::ESCR_BYTES : 5'd0);
        rate_end = escr_end + (flags_held[RATE_FLAG_BIT] ? pes_hdr_pkg::RATE_BYTES : 5'd0);
        if (idx == pes_hdr_pkg::IDX_HDR_LEN)
        begin
            hlen_held   = b;
            field_bytes = '0;
            if (rate_end == 5'd0)
            begin
                pes_active = 1'b0;
                made       = 1'b1;
                summary    = current_summary(pes_hdr_pkg::CLASS_OPT_HDR);
            end
            return;
        end
        pos = idx - pes_hdr_pkg::IDX_HDR_LEN;
        if (pos == pts_end && pts_end != 5'd0)
        begin
            pts_held    = stamp33(field_bytes);
            field_bytes = '0;
        end
        else if (pos == dts_end && dts_end != pts_end)
        begin
            dts_held    = stamp33(field_bytes);
            field_bytes = '0;
        end
        else if (pos == escr_end && escr_end != dts_end)
        begin
            escr_held   = {field_bytes[45:43], field_bytes[41:27], field_bytes[25:11],
                           field_bytes[9:1]};
            field_bytes = '0;
        end
        else if (pos == rate_end && rate_end != escr_end)
        begin
            rate_held   = field_bytes[22:1];
            field_bytes = '0;
        end
        if (pos >= rate_end)
        begin
            pes_active = 1'b0;
            made       = 1'b1;
            summary    = current_summary(pes_hdr_pkg::CLASS_OPT_HDR);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender. Requests go out in bursts of random length; between bursts the
    // valid drops. The payload is held until the parser takes it, and the
    // header state is advanced at that same edge.
    // ------------------------------------------------------------------------
    task automatic send_byte(input pes_hdr_pkg::byte_req_t r, output logic made,
                             output pes_hdr_pkg::hdr_result_t summary);
        if (burst_left == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            if ($urandom_range(0, 3) == 0)
            begin
                burst_left = $urandom_range(40, 120);
            end
            else
            begin
                burst_left = $urandom_range(1, 12);
            end
        end
        burst_left--;
        byte_data  <= r;
        byte_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (byte_stall !== 1'b0);
        requests_sent++;
        parse_byte(r, made, summary);
    endtask

    // Builds one random piece of the stream: mostly complete packets with
    // random content, some packets cut short by the next first byte, and
    // some loose noise with the first-byte mark set at random.
    task automatic queue_random_run();
        logic [7:0]             pkt[$];
        logic [7:0]             sid;
        logic [7:0]             flags_lo;
        pes_hdr_pkg::byte_req_t r;
        int                     kind;
        int                     sel;
        int                     n;
        int                     keep;
        kind = $urandom_range(0, 99);
        if (kind >= 90)
        begin
            repeat ($urandom_range(1, 6))
            begin
                r.data_byte  = 8'($urandom);
                r.first_byte = ($urandom_range(0, 3) == 0);
                packet_bytes.push_back(r);
            end
            return;
        end
        if ($urandom_range(0, 99) < 95)
        begin
            pkt.push_back(pes_hdr_pkg::START_CODE_PREFIX[23:16]);
            pkt.push_back(pes_hdr_pkg::START_CODE_PREFIX[15:8]);
            pkt.push_back(pes_hdr_pkg::START_CODE_PREFIX[7:0]);
        end
        else
        begin
            repeat (3) pkt.push_back(8'($urandom));
        end
        sel = $urandom_range(0, 99);
        if (sel < 50)
        begin
            sid = 8'hC0 + 8'($urandom_range(0, 47));
        end
        else if (sel < 65)
        begin
            sid = data_only_ids[$urandom_range(0, 6)];
        end
        else if (sel < 75)
        begin
            sid = pes_hdr_pkg::SID_PADDING;
        end
        else
        begin
            sid = 8'($urandom);
        end
        pkt.push_back(sid);
        pkt.push_back(8'($urandom));
        pkt.push_back(8'($urandom));
        if (!data_only_sid(sid) && sid != pes_hdr_pkg::SID_PADDING)
        begin
            flags_lo = 8'($urandom);
            pkt.push_back(8'($urandom));
            pkt.push_back(flags_lo);
            pkt.push_back(8'($urandom));
            n = (flags_lo[7] ? int'(pes_hdr_pkg::STAMP_BYTES) : 0)
              + ((flags_lo[7:6] == PTS_AND_DTS) ? int'(pes_hdr_pkg::STAMP_BYTES) : 0)
              + (flags_lo[ESCR_FLAG_BIT] ? int'(pes_hdr_pkg::ESCR_BYTES) : 0)
              + (flags_lo[RATE_FLAG_BIT] ? int'(pes_hdr_pkg::RATE_BYTES) : 0);
            repeat (n) pkt.push_back(8'($urandom));
        end
        if (kind >= 80)
        begin
            keep = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > keep) void'(pkt.pop_back());
        end
        else
        begin
            // Payload bytes after the header are ignored by the parser.
            repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
        end
        foreach (pkt[i])
        begin
            r.data_byte  = pkt[i];
            r.first_byte = (i == 0);
            packet_bytes.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver. It stalls on a pattern of its own: phases of random length in
    // which it never stalls, stalls now and then, or stalls most of the time.
    // Twice in the run it holds off for a long stretch so that the result
    // register stays full and the parser has to stall its input.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (holdoff_left != 0)
        begin
            holdoff_left <= holdoff_left - 1;
            result_stall <= 1'b1;
        end
        else if (cycle_count == HOLDOFF_AT_1 || cycle_count == HOLDOFF_AT_2)
        begin
            holdoff_left <= HOLDOFF_CYCLES;
            result_stall <= 1'b1;
        end
        else
        begin
            if (phase_left == 0)
            begin
                phase_left <= $urandom_range(4, 64);
                rx_mode    <= $urandom_range(RX_FREE, RX_HEAVY);
            end
            else
            begin
                phase_left <= phase_left - 1;
            end
            case (rx_mode)
                RX_FREE:  result_stall <= 1'b0;
                RX_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
                default:  result_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result check. Every summary taken from the parser is compared with the
    // oldest expected one, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : summary_check
        pes_hdr_pkg::hdr_result_t got;
        pes_hdr_pkg::hdr_result_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            got = result_data;
            if (pending_summaries.size() == 0)
            begin
                report_mismatch("summary with none expected, sid_byte",
                                64'(got.sid_byte), 64'd0);
            end
            else
            begin
                want = pending_summaries.pop_front();
                if (got.start_code_ok !== want.start_code_ok)
                    report_mismatch("start_code_ok", 64'(got.start_code_ok),
                                    64'(want.start_code_ok));
                if (got.sid_byte !== want.sid_byte)
                    report_mismatch("sid_byte", 64'(got.sid_byte), 64'(want.sid_byte));
                if (got.packet_length !== want.packet_length)
                    report_mismatch("packet_length", 64'(got.packet_length),
                                    64'(want.packet_length));
                if (got.stream_class !== want.stream_class)
                    report_mismatch("stream_class", 64'(got.stream_class),
                                    64'(want.stream_class));
                if (got.flag_bits !== want.flag_bits)
                    report_mismatch("flag_bits", 64'(got.flag_bits), 64'(want.flag_bits));
                if (got.header_data_length !== want.header_data_length)
                    report_mismatch("header_data_length", 64'(got.header_data_length),
                                    64'(want.header_data_length));
                if (got.pts_value !== want.pts_value)
                    report_mismatch("pts_value", 64'(got.pts_value), 64'(want.pts_value));
                if (got.dts_value !== want.dts_value)
                    report_mismatch("dts_value", 64'(got.dts_value), 64'(want.dts_value));
                if (got.escr_clock !== want.escr_clock)
                    report_mismatch("escr_clock", 64'(got.escr_clock),
                                    64'(want.escr_clock));
                if (got.escr_ext !== want.escr_ext)
                    report_mismatch("escr_ext", 64'(got.escr_ext), 64'(want.escr_ext));
                if (got.es_rate !== want.es_rate)
                    report_mismatch("es_rate", 64'(got.es_rate), 64'(want.es_rate));
                summaries_checked++;
                class_seen[want.stream_class]++;
            end
        end
        if (byte_valid === 1'b1 && byte_stall === 1'b1)
        begin
            input_stall_cycles++;
        end
    end

    // A hung handshake ends the run here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d summaries outstanding.",
                 cycle_count, pending_summaries.size());
        $display("pes_header_parser_test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, the directed table, random packets, then drain.
    // ------------------------------------------------------------------------
    initial
    begin
        pes_hdr_pkg::byte_req_t   r;
        logic                     made;
        pes_hdr_pkg::hdr_result_t summary;

        // Directed bytes. The typed rows close a header whose summary can be
        // read straight off the bytes above them.
        dir_table = '{
            // A stray byte before any packet is ignored.
            '{8'hAA, 1'b0, 1'b0, '0},
            // Padding packet with the largest packet length.
            '{8'h00, 1'b1, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0},
            '{pes_hdr_pkg::SID_PADDING, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b1,
              summary_of(1'b1, pes_hdr_pkg::SID_PADDING, 16'hFFFF,
                         pes_hdr_pkg::CLASS_PADDING, 16'h0000)},
            // Data-only packet behind a bad start code, zero length.
            '{8'hFF, 1'b1, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{pes_hdr_pkg::SID_PROGRAM_MAP, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b1,
              summary_of(1'b0, pes_hdr_pkg::SID_PROGRAM_MAP, 16'h0000,
                         pes_hdr_pkg::CLASS_DATA_ONLY, 16'h0000)},
            // A byte after the summary is ignored.
            '{8'h55, 1'b0, 1'b0, '0},
            // A header cut short by a new first byte gives no summary.
            '{8'h00, 1'b1, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            // Video packet with no optional fields: summary after the
            // header data length byte.
            '{8'h00, 1'b1, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0},
            '{8'hE0, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h80, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b1,
              summary_of(1'b1, 8'hE0, 16'h0000, pes_hdr_pkg::CLASS_OPT_HDR, 16'h8000)}
        };

        pes_active = 1'b0;
        clear_header_state();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[i])
        begin
            r.data_byte  = dir_table[i].data;
            r.first_byte = dir_table[i].first;
            send_byte(r, made, summary);
            if (dir_table[i].typed)
            begin
                pending_summaries.push_back(dir_table[i].want);
            end
            else if (made)
            begin
                pending_summaries.push_back(summary);
            end
        end

        // Random stream. Every byte the parser takes counts toward the
        // target, ignored payload and noise included.
        while (requests_sent < ITEM_TARGET)
        begin
            queue_random_run();
            while (packet_bytes.size() != 0)
            begin
                r = packet_bytes.pop_front();
                send_byte(r, made, summary);
                if (made)
                begin
                    pending_summaries.push_back(summary);
                end
            end
        end
        byte_valid <= 1'b0;

        // Wait for the last summary, then give any stray result time to show.
        while (pending_summaries.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d parsed header bytes); checked %0d summaries: ",
                 requests_sent, parsed_bytes, summaries_checked);
        $display("  %0d optional header, %0d data-only, %0d padding; input stalled %0d cycles.",
                 class_seen[pes_hdr_pkg::CLASS_OPT_HDR],
                 class_seen[pes_hdr_pkg::CLASS_DATA_ONLY],
                 class_seen[pes_hdr_pkg::CLASS_PADDING], input_stall_cycles);
        if (mismatch_count == 0)
        begin
            $display("pes_header_parser_test passed");
        end
        else
        begin
            $display("%0d mismatches found.", mismatch_count);
            $display("pes_header_parser_test failed");
        end
        $finish;
    end

endmodule

// ===== pes_header_parser.f =====
src/pes_hdr_pkg.sv
src/pes_header_parser.sv
test/pes_header_parser_test.sv
